// ===== sv/ptqe_pkg.sv =====
package ptqe_pkg;

  localparam int MAX_SEGMENTS       = 16;
  localparam int SEG_W              = 4;
  localparam int COEFFS_PER_SEGMENT = 6;
  localparam int NUM_AXES           = 2;
  localparam int COEF_DEPTH         = MAX_SEGMENTS * COEFFS_PER_SEGMENT * NUM_AXES;
  localparam int COEF_AW            = $clog2(COEF_DEPTH);
  localparam int VAL_W              = 48;
  localparam int TIME_W             = 32;
  localparam int CNT_W              = 5;
  localparam int PW_W               = 3;
  localparam int START_W            = TIME_W + SEG_W;
  localparam int PROD_W             = VAL_W + TIME_W;
  localparam int HALF_W             = VAL_W / 2;
  localparam int FRAC_T             = 16;
  localparam int Q_DEPTH            = 4;
  localparam int Q_AW               = $clog2(Q_DEPTH);

  localparam logic signed [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [PW_W-1:0]         TOP_PW  = PW_W'(COEFFS_PER_SEGMENT - 1);

  typedef enum logic [1:0] {
    OP_LOAD_DUR  = 2'd0,
    OP_LOAD_COEF = 2'd1,
    OP_EVAL      = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_DUR,
    CMD_COEF,
    CMD_EVAL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [SEG_W-1:0]          seg;
    logic [PW_W-1:0]           pw;
    logic                      axis;
    logic signed [VAL_W-1:0]   coeff;
    logic [TIME_W-1:0]         tval;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SCAN_RD,
    B_SCAN_CMP,
    B_C5_RD,
    B_C5_LD,
    B_MAG,
    B_MUL_LO,
    B_MUL_HI,
    B_RND,
    B_ADD,
    B_DONE
  } back_state_t;

  // coefficient store layout: ((seg*6 + power)*2 + axis)
  function automatic logic [COEF_AW-1:0] coef_addr(input logic [SEG_W-1:0] seg,
                                                   input logic [PW_W-1:0]  pw,
                                                   input logic             axis);
    logic [COEF_AW-1:0] base;
    base = COEF_AW'(seg) * COEF_AW'(COEFFS_PER_SEGMENT * NUM_AXES);
    return base + COEF_AW'({pw, axis});
  endfunction

endpackage

// ===== sv/ptqe_if.sv =====
interface ptqe_in_if import ptqe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic [SEG_W-1:0]        segment;
  logic [PW_W-1:0]         coeff_index;
  logic                    axis;
  logic signed [VAL_W-1:0] coeff_value;
  logic [TIME_W-1:0]       time_value;

  modport source (output valid, op, segment, coeff_index, axis, coeff_value, time_value,
                  input ready);
  modport sink   (input valid, op, segment, coeff_index, axis, coeff_value, time_value,
                  output ready);
endinterface

interface ptqe_out_if import ptqe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] pos_x;
  logic signed [VAL_W-1:0] pos_y;
  logic [SEG_W-1:0]        segment_used;
  logic                    past_end;
  logic                    saturated;

  modport source (output valid, pos_x, pos_y, segment_used, past_end, saturated,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, segment_used, past_end, saturated,
                  output ready);
endinterface

// ===== sv/piecewise_quintic_trajectory_eval_unit.sv =====
// Piecewise quintic trajectory evaluator, x and y axes, up to 16 segments.
// Input channel in_ch carries requests: load a segment duration (op 0),
// load one Q24.24 coefficient (op 1) or evaluate at a Q16.16 time (op 2).
// Loads produce nothing; each evaluate produces one request on out_ch with
// both positions, the segment hit, a past-end flag and a saturation flag.
// cfg_we/cfg_wdata set the number of segments in use; write only when idle.
// Requests pass a one-entry classify stage and a 4-deep queue, so in_ch keeps
// taking requests while the evaluator works or out_ch is stalled.
// Loads are retired at the evaluator while it is idle. An evaluate walks
// the segments up to the one hit (one duration read and compare per
// segment), then runs the two Horner chains (fetch c5, then per step:
// magnitude, two 24x32 partial products, round/saturate, add/saturate)
// before raising out_ch.valid. The result sits in the output registers
// until out_ch.ready; the evaluator waits there, and in_ch backs up only
// once the queue fills.
// Reset (rst_n low, synchronous) empties the queue, drops any evaluation and
// sets segment count to 1. Table contents are undefined until loaded.
module piecewise_quintic_trajectory_eval_unit import ptqe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  ptqe_in_if.sink          in_ch,
  ptqe_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0] seg_count_r;

  // classified request handed from front to queue
  logic push_valid;
  cmd_t push_cmd;
  logic push_ready;

  // queue head to evaluator
  logic pop_valid;
  cmd_t pop_cmd;
  logic pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= CNT_W'(1);
    end else if (cfg_we) begin
      seg_count_r <= cfg_wdata;
    end
  end

  // front: accepts requests, drops no-ops, tags the kind
  ptqe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // decoupling queue; keeps load/evaluate order
  ptqe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  // back: table writes, segment walk, Horner evaluation, result register
  ptqe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_count (seg_count_r),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

// ===== sv/ptqe_ram.sv =====
module ptqe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== sv/ptqe_front.sv =====
module ptqe_front import ptqe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  ptqe_in_if.sink      in_ch,
  output logic         push_valid,
  output cmd_t         push_cmd,
  input  logic         push_ready
);

  logic      fv_r;
  cmd_t      cmd_r;
  logic      accept;
  logic      keep;
  cmd_kind_t kind;

  assign in_ch.ready = !fv_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // drop what leaves no trace: unused op, coefficient power out of range
  always_comb begin
    keep = 1'b0;
    kind = CMD_EVAL;
    case (op_t'(in_ch.op))
      OP_LOAD_DUR: begin
        keep = 1'b1;
        kind = CMD_DUR;
      end
      OP_LOAD_COEF: begin
        keep = (in_ch.coeff_index < PW_W'(COEFFS_PER_SEGMENT));
        kind = CMD_COEF;
      end
      OP_EVAL: begin
        keep = 1'b1;
        kind = CMD_EVAL;
      end
      default: begin
        keep = 1'b0;
        kind = CMD_EVAL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (accept) begin
      fv_r <= keep;
    end else if (push_ready) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.kind  <= kind;
      cmd_r.seg   <= in_ch.segment;
      cmd_r.pw    <= in_ch.coeff_index;
      cmd_r.axis  <= in_ch.axis;
      cmd_r.coeff <= in_ch.coeff_value;
      cmd_r.tval  <= in_ch.time_value;
    end
  end

  assign push_valid = fv_r;
  assign push_cmd   = cmd_r;

endmodule

// ===== sv/ptqe_queue.sv =====
module ptqe_queue import ptqe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop_ready
);

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (cnt_r != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/ptqe_back.sv =====
module ptqe_back import ptqe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] seg_count,
  input  logic             pop_valid,
  input  cmd_t             pop_cmd,
  output logic             pop_ready,
  ptqe_out_if.source       out_ch
);

  back_state_t state_r, state_nxt;

  logic [TIME_W-1:0]       t_r;
  logic [START_W-1:0]      start_r;
  logic [SEG_W-1:0]        seg_r;
  logic [TIME_W-1:0]       u_r;
  logic                    past_r;
  logic                    sat_r;
  logic                    axis_r;
  logic [PW_W-1:0]         k_r;
  logic signed [VAL_W-1:0] acc_r;
  logic [VAL_W-1:0]        mag_r;
  logic                    neg_r;
  logic [PROD_W-1:0]       prod_r;
  logic signed [VAL_W-1:0] mres_r;
  logic signed [VAL_W-1:0] px_r;
  logic signed [VAL_W-1:0] py_r;

  // memory ports
  logic                    dur_we, dur_re;
  logic [TIME_W-1:0]       dur_rdata;
  logic                    coef_we, coef_re;
  logic [COEF_AW-1:0]      coef_waddr, coef_raddr;
  logic [VAL_W-1:0]        coef_rdata;
  logic signed [VAL_W-1:0] coef_val;

  logic [SEG_W-1:0]        last_seg;
  logic [START_W:0]        scan_end;
  logic                    beyond;
  logic                    eval_pop;
  logic [HALF_W-1:0]       mul_a;
  logic [HALF_W+TIME_W-1:0] mul_p;
  logic [PROD_W-1:0]       rnd_sum;
  logic [PROD_W-FRAC_T-1:0] rnd_m;
  logic signed [VAL_W:0]   add_sum;
  logic signed [VAL_W-1:0] add_res;
  logic                    add_ovf;

  ptqe_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SEGMENTS)) u_dur_ram (
    .clk   (clk),
    .we    (dur_we),
    .waddr (pop_cmd.seg),
    .wdata (pop_cmd.tval),
    .re    (dur_re),
    .raddr (seg_r),
    .rdata (dur_rdata)
  );

  ptqe_ram #(.WIDTH(VAL_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (pop_cmd.coeff),
    .re    (coef_re),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  assign coef_val = $signed(coef_rdata);

  // segment count of 0 acts as 1, above the table as the table size
  always_comb begin
    if (seg_count == '0) begin
      last_seg = '0;
    end else if (seg_count > CNT_W'(MAX_SEGMENTS)) begin
      last_seg = SEG_W'(MAX_SEGMENTS - 1);
    end else begin
      last_seg = SEG_W'(seg_count - 1'b1);
    end
  end

  assign scan_end = {1'b0, start_r} + (START_W+1)'(dur_rdata);
  assign beyond   = ((START_W+1)'(t_r) > scan_end);
  assign eval_pop = (state_r == B_IDLE) && pop_valid && (pop_cmd.kind == CMD_EVAL);

  // one 24x32 multiplier, low half then high half of the magnitude
  assign mul_a = (state_r == B_MUL_LO) ? mag_r[HALF_W-1:0] : mag_r[VAL_W-1:HALF_W];
  assign mul_p = (HALF_W+TIME_W)'(mul_a) * (HALF_W+TIME_W)'(u_r);

  assign rnd_sum = prod_r + PROD_W'(1 << (FRAC_T - 1));
  assign rnd_m   = rnd_sum[PROD_W-1:FRAC_T];

  assign add_sum = {mres_r[VAL_W-1], mres_r} + {coef_val[VAL_W-1], coef_val};
  assign add_ovf = (add_sum[VAL_W] != add_sum[VAL_W-1]);
  assign add_res = add_ovf ? (add_sum[VAL_W] ? NEG_MIN : POS_MAX) : add_sum[VAL_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:     if (eval_pop) state_nxt = B_SCAN_RD;
      B_SCAN_RD:  state_nxt = B_SCAN_CMP;
      B_SCAN_CMP: begin
        if (beyond && (seg_r != last_seg)) begin
          state_nxt = B_SCAN_RD;
        end else begin
          state_nxt = B_C5_RD;
        end
      end
      B_C5_RD:    state_nxt = B_C5_LD;
      B_C5_LD:    state_nxt = B_MAG;
      B_MAG:      state_nxt = B_MUL_LO;
      B_MUL_LO:   state_nxt = B_MUL_HI;
      B_MUL_HI:   state_nxt = B_RND;
      B_RND:      state_nxt = B_ADD;
      B_ADD: begin
        if (k_r != '0) begin
          state_nxt = B_MAG;
        end else if (!axis_r) begin
          state_nxt = B_C5_RD;
        end else begin
          state_nxt = B_DONE;
        end
      end
      B_DONE:     if (out_ch.ready) state_nxt = B_IDLE;
      default:    state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_ready  = 1'b0;
    dur_we     = 1'b0;
    dur_re     = 1'b0;
    coef_we    = 1'b0;
    coef_re    = 1'b0;
    coef_waddr = coef_addr(pop_cmd.seg, pop_cmd.pw, pop_cmd.axis);
    coef_raddr = coef_addr(seg_r, k_r, axis_r);
    case (state_r)
      B_IDLE: begin
        pop_ready = 1'b1;
        dur_we    = pop_valid && (pop_cmd.kind == CMD_DUR);
        coef_we   = pop_valid && (pop_cmd.kind == CMD_COEF);
      end
      B_SCAN_RD: dur_re = 1'b1;
      B_C5_RD: begin
        coef_re    = 1'b1;
        coef_raddr = coef_addr(seg_r, TOP_PW, axis_r);
      end
      B_MUL_LO:  coef_re = 1'b1;
      default: begin
        pop_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (eval_pop) begin
          t_r     <= pop_cmd.tval;
          start_r <= '0;
          seg_r   <= '0;
          past_r  <= 1'b0;
          sat_r   <= 1'b0;
          axis_r  <= 1'b0;
        end
      end
      B_SCAN_CMP: begin
        if (beyond) begin
          if (seg_r == last_seg) begin
            past_r <= 1'b1;
            u_r    <= dur_rdata;
          end else begin
            start_r <= start_r + START_W'(dur_rdata);
            seg_r   <= seg_r + 1'b1;
          end
        end else begin
          u_r <= t_r - start_r[TIME_W-1:0];
        end
      end
      B_C5_LD: begin
        acc_r <= coef_val;
        k_r   <= TOP_PW - 1'b1;
      end
      B_MAG: begin
        neg_r <= acc_r[VAL_W-1];
        mag_r <= acc_r[VAL_W-1] ? VAL_W'(-acc_r) : VAL_W'(acc_r);
      end
      B_MUL_LO: prod_r <= PROD_W'(mul_p);
      B_MUL_HI: prod_r <= prod_r + {mul_p, {HALF_W{1'b0}}};
      B_RND: begin
        if (neg_r) begin
          // magnitude limit 2^47, zero-extended to the rounded width
          if (rnd_m > {{(PROD_W-FRAC_T-VAL_W){1'b0}}, NEG_MIN}) begin
            mres_r <= NEG_MIN;
            sat_r  <= 1'b1;
          end else begin
            mres_r <= -$signed(rnd_m[VAL_W-1:0]);
          end
        end else begin
          if (rnd_m > (PROD_W-FRAC_T)'(POS_MAX)) begin
            mres_r <= POS_MAX;
            sat_r  <= 1'b1;
          end else begin
            mres_r <= $signed(rnd_m[VAL_W-1:0]);
          end
        end
      end
      B_ADD: begin
        acc_r <= add_res;
        if (add_ovf) begin
          sat_r <= 1'b1;
        end
        if (k_r != '0) begin
          k_r <= k_r - 1'b1;
        end else if (!axis_r) begin
          px_r   <= add_res;
          axis_r <= 1'b1;
        end else begin
          py_r <= add_res;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid        = (state_r == B_DONE);
  assign out_ch.pos_x        = px_r;
  assign out_ch.pos_y        = py_r;
  assign out_ch.segment_used = seg_r;
  assign out_ch.past_end     = past_r;
  assign out_ch.saturated    = sat_r;

endmodule

// ===== sv/ptqe_checker.sv =====
module ptqe_checker import ptqe_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] pos_x,
  input logic signed [VAL_W-1:0] pos_y,
  input logic [SEG_W-1:0]        segment_used,
  input logic                    past_end,
  input logic                    saturated
);

  // nothing left pending after reset
  a_rst_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // queue and front empty after reset, so input must be open
  a_rst_in_open: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // one result per evaluate: a delivered result is never shown again
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated after handshake");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
      && $stable(segment_used) && $stable(past_end) && $stable(saturated))
    else $error("stalled result changed");

  // a stalled request stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input request withdrawn while stalled");

endmodule

bind piecewise_quintic_trajectory_eval_unit ptqe_checker u_ptqe_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pos_x        (out_ch.pos_x),
  .pos_y        (out_ch.pos_y),
  .segment_used (out_ch.segment_used),
  .past_end     (out_ch.past_end),
  .saturated    (out_ch.saturated)
);

// ===== sim/piecewise_quintic_trajectory_eval_unit_tb.sv =====
module piecewise_quintic_trajectory_eval_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptqe_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 5;
  // generous margin after the last result
  localparam int SETTLE_CYCLES   = 128;
  localparam int HOLD_OFF_CYCLES = 800;
  // longest quiet stretch in a good run is the receiver hold-off
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int REPORT_LIMIT    = 10;

  localparam logic [1:0]        OP_RESERVED = 2'd3;
  localparam logic [TIME_W-1:0] ONE_SECOND  = 32'h0001_0000;
  localparam logic [TIME_W-1:0] HALF_SECOND = 32'h0000_8000;
  localparam logic [TIME_W-1:0] TIME_MAX    = '1;
  localparam longint unsigned   MAG_LIMIT   = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic [1:0]              op;
    logic [SEG_W-1:0]        segment;
    logic [PW_W-1:0]         power;
    logic                    axis;
    logic signed [VAL_W-1:0] coeff;
    logic [TIME_W-1:0]       tval;
  } traj_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic [SEG_W-1:0]        seg;
    logic                    past;
    logic                    sat;
  } traj_point_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             hold_out;

  ptqe_in_if  in_ch ();
  ptqe_out_if out_ch ();

  piecewise_quintic_trajectory_eval_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Shadow of the block's tables and segment count, updated on acceptance.
  logic [TIME_W-1:0]       dur_mem   [MAX_SEGMENTS];
  logic signed [VAL_W-1:0] coeff_mem [MAX_SEGMENTS][COEFFS_PER_SEGMENT][NUM_AXES];
  logic [CNT_W-1:0]        seg_count;
  traj_point_t             expected_q [$];

  int in_idle_pct;
  int out_idle_pct;
  int requests_sent;
  int results_checked;
  int past_end_hits;
  int sat_hits;
  int cfg_writes;
  int mismatches;
  int quiet_cycles;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // count 0 behaves as 1, anything above the table size as the table size
  function automatic int active_segments();
    if (seg_count == 0) return 1;
    if (seg_count > MAX_SEGMENTS) return MAX_SEGMENTS;
    return int'(seg_count);
  endfunction

  function automatic logic [START_W:0] active_span();
    logic [START_W:0] sum;
    sum = '0;
    for (int i = 0; i < active_segments(); i++) sum += dur_mem[i];
    return sum;
  endfunction

  // Q24.24 * Q16.16 -> Q24.24, round half away from zero on the magnitude,
  // clamp to 48 bits
  function automatic logic signed [VAL_W-1:0] scale_by_time(
      input logic signed [VAL_W-1:0] acc, input logic [TIME_W-1:0] u, inout logic sat);
    logic [VAL_W-1:0]        mag;
    logic [PROD_W:0]         prod;
    logic [PROD_W-FRAC_T:0]  m;
    mag  = acc[VAL_W-1] ? VAL_W'(-acc) : VAL_W'(acc);
    prod = mag * u + (PROD_W+1)'(1 << (FRAC_T - 1));
    m    = prod[PROD_W:FRAC_T];
    if (acc[VAL_W-1]) begin
      if (m > MAG_LIMIT) begin
        sat = 1'b1;
        return NEG_MIN;
      end
      return -m[VAL_W-1:0];
    end
    if (m >= MAG_LIMIT) begin
      sat = 1'b1;
      return POS_MAX;
    end
    return m[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] add_saturating(
      input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b, inout logic sat);
    logic signed [VAL_W:0] s;
    s = a + b;
    if (s[VAL_W] != s[VAL_W-1]) begin
      sat = 1'b1;
      return s[VAL_W] ? NEG_MIN : POS_MAX;
    end
    return s[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] eval_axis(
      input int seg, input int ax, input logic [TIME_W-1:0] u, inout logic sat);
    logic signed [VAL_W-1:0] acc;
    acc = coeff_mem[seg][TOP_PW][ax];
    for (int k = COEFFS_PER_SEGMENT - 2; k >= 0; k--) begin
      acc = scale_by_time(acc, u, sat);
      acc = add_saturating(acc, coeff_mem[seg][k][ax], sat);
    end
    return acc;
  endfunction

  // Walk segments by running sum; a time on a boundary stays in the earlier one.
  function automatic traj_point_t predict_point(input logic [TIME_W-1:0] t);
    traj_point_t      p;
    logic [START_W:0] start;
    logic [TIME_W-1:0] u;
    logic             sat;
    int               cnt;
    int               s;
    cnt   = active_segments();
    s     = 0;
    start = '0;
    sat   = 1'b0;
    while (s < cnt && t > start + dur_mem[s]) begin
      start += dur_mem[s];
      s++;
    end
    if (s >= cnt) begin
      // clamp to the end of the last segment in use
      s      = cnt - 1;
      u      = dur_mem[s];
      p.past = 1'b1;
    end else begin
      u      = t - start[TIME_W-1:0];
      p.past = 1'b0;
    end
    p.pos_x = eval_axis(s, 0, u, sat);
    p.pos_y = eval_axis(s, 1, u, sat);
    p.seg   = SEG_W'(s);
    p.sat   = sat;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // every field random; callers override what the op uses
  function automatic traj_req_t rand_request();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(traj_req_t)-1:0];
  endfunction

  // signed value of random width, so both tiny and full-scale values show up
  function automatic logic signed [VAL_W-1:0] rand_coeff();
    logic signed [63:0] w;
    int                 n;
    n = $urandom_range(1, VAL_W);
    w = $signed({$urandom, $urandom});
    w = w >>> (64 - n);
    return w[VAL_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] rand_duration();
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom;
      2:       return $urandom >> $urandom_range(TIME_W - 1);
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  // Query times aimed at segment edges, interiors and past the end.
  function automatic logic [TIME_W-1:0] rand_query();
    logic [START_W:0] start;
    logic [START_W:0] stop;
    int               k;
    k     = $urandom_range(active_segments() - 1);
    start = '0;
    for (int i = 0; i < k; i++) start += dur_mem[i];
    stop = start + dur_mem[k];
    case ($urandom_range(7))
      0:       return TIME_W'(stop);
      1:       return TIME_W'(stop + 1);
      2:       return TIME_W'(stop - 1);
      3:       return TIME_W'(start + ($urandom % (longint'(dur_mem[k]) + 1)));
      4:       return TIME_W'(active_span() + $urandom_range(1, 4096));
      5:       return '0;
      6:       return TIME_MAX;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request, wait for the handshake, then update the shadow state.
  task automatic send_request(input traj_req_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= r.op;
    in_ch.segment     <= r.segment;
    in_ch.coeff_index <= r.power;
    in_ch.axis        <= r.axis;
    in_ch.coeff_value <= r.coeff;
    in_ch.time_value  <= r.tval;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
    case (r.op)
      OP_LOAD_DUR:  dur_mem[r.segment] = r.tval;
      OP_LOAD_COEF: begin
        if (r.power < COEFFS_PER_SEGMENT) coeff_mem[r.segment][r.power][r.axis] = r.coeff;
      end
      OP_EVAL:      expected_q = {expected_q, predict_point(r.tval)};
      default:      ;
    endcase
  endtask

  task automatic send_eval(input logic [TIME_W-1:0] t);
    traj_req_t r;
    r      = rand_request();
    r.op   = OP_EVAL;
    r.tval = t;
    send_request(r);
  endtask

  task automatic send_duration(input int seg, input logic [TIME_W-1:0] d);
    traj_req_t r;
    r         = rand_request();
    r.op      = OP_LOAD_DUR;
    r.segment = SEG_W'(seg);
    r.tval    = d;
    send_request(r);
  endtask

  task automatic send_coeff(input int seg, input int pw, input int ax,
                            input logic signed [VAL_W-1:0] v);
    traj_req_t r;
    r         = rand_request();
    r.op      = OP_LOAD_COEF;
    r.segment = SEG_W'(seg);
    r.power   = PW_W'(pw);
    r.axis    = ax[0];
    r.coeff   = v;
    send_request(r);
  endtask

  task automatic send_noise();
    traj_req_t r;
    r    = rand_request();
    r.op = OP_RESERVED;
    send_request(r);
  endtask

  task automatic reload_segment(input int seg, input logic [TIME_W-1:0] d);
    send_duration(seg, d);
    for (int pw = 0; pw < COEFFS_PER_SEGMENT; pw++)
      for (int ax = 0; ax < NUM_AXES; ax++) send_coeff(seg, pw, ax, rand_coeff());
  endtask

  // Wait out every pending result, then the tail of any trailing loads.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_segment_count(input logic [CNT_W-1:0] v);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seg_count = v;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill every duration and coefficient so no evaluation reads an unwritten
  // entry; durations kept moderate so totals stay inside 32-bit time.
  task automatic test_preload_tables();
    for (int s = 0; s < MAX_SEGMENTS; s++)
      reload_segment(s, $urandom_range(32'h0000_0100, 32'h0008_0000));
  endtask

  // reset count of one segment: start, exact end, just past, far past
  task automatic test_boundaries_single_segment();
    send_eval('0);
    send_eval(dur_mem[0]);
    send_eval(dur_mem[0] + 1);
    send_eval(TIME_MAX);
  endtask

  // reserved op and out-of-range powers must leave the tables alone
  task automatic test_ignored_requests();
    send_noise();
    send_coeff(0, COEFFS_PER_SEGMENT, 0, POS_MAX);
    send_coeff(0, (1 << PW_W) - 1, 1, NEG_MIN);
    send_eval(dur_mem[0] >> 1);
  endtask

  task automatic test_segment_walk();
    logic [START_W:0] total;
    write_segment_count(CNT_W'(MAX_SEGMENTS));
    total = active_span();
    send_eval(dur_mem[0]);
    send_eval(dur_mem[0] + 1);
    send_eval(TIME_W'(total - (dur_mem[MAX_SEGMENTS-1] >> 1)));
    send_eval(TIME_W'(total));
    send_eval(TIME_W'(total + 1));
  endtask

  task automatic test_count_clamp();
    write_segment_count('0);
    send_eval(TIME_MAX);
    write_segment_count('1);
    send_eval(TIME_MAX);
    write_segment_count(CNT_W'(MAX_SEGMENTS + 1));
    send_eval(TIME_W'(active_span()));
  endtask

  // full-scale top coefficients: overflow both ways, exact unit time,
  // and a half-way rounding tie on a negative value
  task automatic test_saturation();
    write_segment_count(CNT_W'(1));
    send_duration(0, TIME_MAX);
    send_coeff(0, TOP_PW, 0, POS_MAX);
    send_coeff(0, TOP_PW, 1, NEG_MIN);
    send_eval(TIME_MAX);
    send_eval(ONE_SECOND);
    send_coeff(0, TOP_PW, 0, -1);
    send_eval(HALF_SECOND);
  endtask

  // Mostly queries on well-loaded segments, with reloads, single loads,
  // ignored requests and count changes sprinkled in.
  task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                     input int n_requests);
    int goal;
    int chunk_left;
    int pick;
    in_idle_pct  = sender_idle;
    out_idle_pct = receiver_idle;
    goal         = requests_sent + n_requests;
    chunk_left   = 0;
    while (requests_sent < goal) begin
      if (chunk_left == 0) begin
        case ($urandom_range(9))
          0:       write_segment_count('0);
          1:       write_segment_count(CNT_W'(1));
          2:       write_segment_count(CNT_W'(MAX_SEGMENTS));
          3:       write_segment_count(CNT_W'(MAX_SEGMENTS + 1));
          4:       write_segment_count('1);
          default: write_segment_count(CNT_W'($urandom_range(1, MAX_SEGMENTS)));
        endcase
        chunk_left = $urandom_range(40, 90);
      end
      chunk_left--;
      pick = $urandom_range(99);
      if (pick < 55)
        send_eval(rand_query());
      else if (pick < 63)
        reload_segment($urandom_range(MAX_SEGMENTS - 1), rand_duration());
      else if (pick < 76)
        send_coeff($urandom_range(MAX_SEGMENTS - 1), $urandom_range(TOP_PW),
                   $urandom_range(1), rand_coeff());
      else if (pick < 86)
        send_duration($urandom_range(MAX_SEGMENTS - 1), rand_duration());
      else if (pick < 90)
        send_coeff($urandom_range(MAX_SEGMENTS - 1),
                   $urandom_range(COEFFS_PER_SEGMENT, (1 << PW_W) - 1),
                   $urandom_range(1), rand_coeff());
      else if (pick < 94)
        send_noise();
      else
        send_eval($urandom);
    end
  endtask

  // Receiver goes dark for a long stretch while the sender keeps pushing
  // queries: the internal queue fills and in_ch.ready must drop.
  task automatic test_receiver_backpressure();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    fork
      begin
        hold_out <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
      end
    join_none
    repeat (12) send_eval(rand_query());
    drain_block();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking, receiver ready and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    traj_point_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%t ERROR unrequested result x=%h y=%h seg=%0d past=%b sat=%b", $realtime,
                   out_ch.pos_x, out_ch.pos_y, out_ch.segment_used, out_ch.past_end,
                   out_ch.saturated);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (want.past) past_end_hits++;
        if (want.sat) sat_hits++;
        if (out_ch.pos_x !== want.pos_x || out_ch.pos_y !== want.pos_y ||
            out_ch.segment_used !== want.seg || out_ch.past_end !== want.past ||
            out_ch.saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"%t ERROR result %0d: exp x=%h y=%h seg=%0d past=%b sat=%b",
                      " / got x=%h y=%h seg=%0d past=%b sat=%b"}, $realtime,
                     results_checked, want.pos_x, want.pos_y, want.seg, want.past,
                     want.sat, out_ch.pos_x, out_ch.pos_y, out_ch.segment_used,
                     out_ch.past_end, out_ch.saturated);
        end
      end
    end

    out_ch.ready <= rst_n && !hold_out && ($urandom_range(99) >= out_idle_pct);

    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("piecewise_quintic_trajectory_eval_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= '0;
    in_ch.segment     <= '0;
    in_ch.coeff_index <= '0;
    in_ch.axis        <= 1'b0;
    in_ch.coeff_value <= '0;
    in_ch.time_value  <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    hold_out          <= 1'b0;
    seg_count         = CNT_W'(1);
    requests_sent     = 0;
    results_checked   = 0;
    past_end_hits     = 0;
    sat_hits          = 0;
    cfg_writes        = 0;
    mismatches        = 0;
    quiet_cycles      = 0;
    in_idle_pct       = 8;
    out_idle_pct      = 66;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_preload_tables();
    test_boundaries_single_segment();
    test_ignored_requests();
    test_segment_walk();
    test_count_clamp();
    test_saturation();
    test_random_traffic(8, 66, 390);
    test_random_traffic(66, 8, 390);
    test_receiver_backpressure();
    test_random_traffic(0, 0, 390);
    drain_block();

    $display("run: %0d requests, %0d evaluations checked (%0d clamped past end, %0d saturated)",
             requests_sent, results_checked, past_end_hits, sat_hits);
    $display("run: %0d segment-count writes, three idle mixes and one long output hold-off",
             cfg_writes);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("piecewise_quintic_trajectory_eval_unit: match");
    else
      $display("piecewise_quintic_trajectory_eval_unit: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ptqe_pkg.sv
sv/ptqe_if.sv
sv/ptqe_ram.sv
sv/ptqe_front.sv
sv/ptqe_queue.sv
sv/ptqe_back.sv
sv/piecewise_quintic_trajectory_eval_unit.sv
sv/ptqe_checker.sv
sim/piecewise_quintic_trajectory_eval_unit_tb.sv
